// ===== hw/rtl/psmdb_pkg.sv =====
// ============================================================================
// psmdb_pkg: shared types and constants for the point splat depth buffer
// Request and response formats, register indexes and default store size.
// ============================================================================
package psmdb_pkg;

    // Default store size
    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 256;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int SIZE_W     = 9;
    // Wide enough for a size limit up to 4096
    localparam int LIM_W      = 13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_C0A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C0B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_C1A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C1B  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_C2A  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_C2B  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 3'd7;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    // Homogeneous coordinate 1.0 in Q16.16
    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
    localparam int N_TERMS = 4;

    // Request classes
    typedef enum logic [1:0] {
        OP_SPLAT,
        OP_READ,
        OP_NULL
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] val;
        logic [7:0]         row;
        logic [7:0]         col;
    } t_req;

    typedef struct packed {
        logic               landed;
        logic [7:0]         hit_row;
        logic [7:0]         hit_col;
        logic signed [31:0] pixel_value;
    } t_rsp;

endpackage

// ===== hw/rtl/psmdb_if.sv =====
// ============================================================================
// psmdb_in_if / psmdb_out_if: request and result channels
// Valid/ready channels carrying one request or one result.
// ============================================================================
interface psmdb_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] point_value;
    logic [7:0]         read_row;
    logic [7:0]         read_col;

    modport source (output valid, kind, point_x, point_y, point_z, point_value,
                    read_row, read_col, input ready);
    modport sink (input valid, kind, point_x, point_y, point_z, point_value,
                  read_row, read_col, output ready);
endinterface

interface psmdb_out_if;
    logic               valid;
    logic               ready;
    logic               landed;
    logic [7:0]         hit_row;
    logic [7:0]         hit_col;
    logic signed [31:0] pixel_value;

    modport source (output valid, landed, hit_row, hit_col, pixel_value,
                    input ready);
    modport sink (input valid, landed, hit_row, hit_col, pixel_value,
                  output ready);
endinterface

// ===== hw/rtl/psmdb_ram.sv =====
// ============================================================================
// psmdb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module psmdb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/psmdb_front.sv =====
// ============================================================================
// psmdb_front: request intake and classification
// Accepts requests, sorts them into splat, read and null, and queues them.
// ============================================================================
module psmdb_front #(
    parameter int MAX_ROWS = psmdb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = psmdb_pkg::MAX_COLS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    psmdb_in_if.sink        i_in,
    input  logic            i_clearing,
    input  logic            i_pop,
    output psmdb_pkg::t_req o_head,
    output logic            o_head_valid
);
    psmdb_pkg::t_req r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            push;
    logic            pop;
    logic            in_range;
    psmdb_pkg::t_req req;

    // Classify the incoming request
    always_comb begin
        in_range = (16'(i_in.read_row) < 16'(MAX_ROWS)) &&
                   (16'(i_in.read_col) < 16'(MAX_COLS));
        req.x   = i_in.point_x;
        req.y   = i_in.point_y;
        req.z   = i_in.point_z;
        req.val = i_in.point_value;
        req.row = i_in.read_row;
        req.col = i_in.read_col;
        if (!i_in.kind) begin
            req.op = psmdb_pkg::OP_SPLAT;
        end else if (in_range) begin
            req.op = psmdb_pkg::OP_READ;
        end else begin
            req.op = psmdb_pkg::OP_NULL;
        end
    end

    assign i_in.ready   = (r_cnt != 2'd2) && !i_clearing;
    assign push         = i_in.valid && i_in.ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign pop          = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rp];

    // Advance queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // Hold queued requests
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= req;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_no_push_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clearing |-> !push) else $error("request taken during clearing");
endmodule

// ===== hw/rtl/psmdb_div.sv =====
// ============================================================================
// psmdb_div: restoring divider for a short quotient
// Produces QW quotient bits of a 64-bit division, one bit a cycle,
// and flags a quotient too large for QW bits.
// ============================================================================
module psmdb_div #(
    parameter int QW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_num,
    input  logic [63:0]   i_den,
    output logic          o_busy,
    output logic [QW-1:0] o_q,
    output logic          o_ovf
);
    localparam int CNTW = $clog2(QW + 1);

    logic [CNTW-1:0] r_cnt;
    logic [63:0]     r_rem;
    logic [QW-1:0]   r_lo;
    logic [63:0]     r_den;
    logic [QW-1:0]   r_q;
    logic            r_ovf;
    logic [64:0]     rem_sh;
    logic [64:0]     rem_nx;
    logic            ge;
    logic [QW:0]     q_sh;

    // One restoring step
    always_comb begin
        rem_sh = {r_rem, r_lo[QW-1]};
        ge     = rem_sh >= {1'b0, r_den};
        rem_nx = rem_sh - {1'b0, r_den};
        q_sh   = {r_q, ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(QW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Load operands, then shift in quotient bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num >> QW;
            r_lo  <= i_num[QW-1:0];
            r_den <= i_den;
            r_ovf <= (i_num >> QW) >= i_den;
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? rem_nx[63:0] : rem_sh[63:0];
            r_lo  <= r_lo << 1;
            r_q   <= q_sh[QW-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_q    = r_q;
    assign o_ovf  = r_ovf;
endmodule

// ===== hw/rtl/psmdb_back.sv =====
// ============================================================================
// psmdb_back: projection, pixel update and result register
// Runs each queued request: projects splats, divides, and updates the
// pixel store by read-modify-write; clears the store after reset.
// ============================================================================
module psmdb_back #(
    parameter int MAX_ROWS = psmdb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = psmdb_pkg::MAX_COLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psmdb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [psmdb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  psmdb_pkg::t_req                     i_head,
    input  logic                                i_head_valid,
    output logic                                o_pop,
    output logic                                o_clearing,
    psmdb_out_if.source                         o_out
);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int QW    = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);
    localparam int LW    = psmdb_pkg::LIM_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_FOLD, S_DIVGO, S_DIV, S_CHECK, S_RMW, S_RDATA
    } t_state;

    t_state                         r_state;
    logic [AW-1:0]                  r_clr;
    logic [63:0]                    r_coef [6];
    logic [psmdb_pkg::SIZE_W-1:0]   r_rows;
    logic [psmdb_pkg::SIZE_W-1:0]   r_cols;
    logic [2:0]                     r_term;
    logic signed [31:0]             r_x;
    logic signed [31:0]             r_y;
    logic signed [31:0]             r_z;
    logic signed [31:0]             r_val;
    logic signed [63:0]             r_prod [3];
    logic [63:0]                    r_pos [3];
    logic [63:0]                    r_neg [3];
    logic                           r_sgn [3];
    logic [63:0]                    r_mag [3];
    logic [AW-1:0]                  r_addr;
    logic [7:0]                     r_hit_row;
    logic [7:0]                     r_hit_col;
    logic                           r_out_valid;
    psmdb_pkg::t_rsp                r_out;

    logic signed [31:0]             opa [3];
    logic signed [31:0]             opb [3];
    logic                           out_free;
    logic                           out_load;
    logic                           div_start;
    logic                           busy_u;
    logic                           busy_v;
    logic [QW-1:0]                  q_u;
    logic [QW-1:0]                  q_v;
    logic                           ovf_u;
    logic                           ovf_v;
    logic [LW-1:0]                  lim_rows;
    logic [LW-1:0]                  lim_cols;
    logic [LW-1:0]                  col_i;
    logic [LW-1:0]                  row_i;
    logic                           u_ok;
    logic                           v_ok;
    logic                           land;
    logic [AW-1:0]                  hit_addr;
    logic [15:0]                    rd_row;
    logic [15:0]                    rd_col;
    logic [AW-1:0]                  rd_addr;
    logic signed [31:0]             stored;
    logic                           upd;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [31:0]                    ram_wdata;
    logic                           ram_re;
    logic [AW-1:0]                  ram_raddr;
    logic [31:0]                    ram_rdata;

    assign out_free   = !r_out_valid || o_out.ready;
    assign o_clearing = (r_state == S_CLEAR);
    assign div_start  = (r_state == S_DIVGO);

    // Select multiplier operands for the current term of each matrix row
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            unique case (r_term[1:0])
                2'd0: begin
                    opa[r] = r_coef[2*r][31:0];
                    opb[r] = r_x;
                end
                2'd1: begin
                    opa[r] = r_coef[2*r][63:32];
                    opb[r] = r_y;
                end
                2'd2: begin
                    opa[r] = r_coef[2*r+1][31:0];
                    opb[r] = r_z;
                end
                default: begin
                    opa[r] = r_coef[2*r+1][63:32];
                    opb[r] = psmdb_pkg::Q_ONE;
                end
            endcase
        end
    end

    // Landing test on the divider results
    always_comb begin
        lim_rows = (LW'(r_rows) < LW'(MAX_ROWS)) ? LW'(r_rows) : LW'(MAX_ROWS);
        lim_cols = (LW'(r_cols) < LW'(MAX_COLS)) ? LW'(r_cols) : LW'(MAX_COLS);
        u_ok  = (r_mag[2] != '0) &&
                ((r_mag[0] == '0) || ((r_sgn[0] == r_sgn[2]) && !ovf_u));
        v_ok  = (r_mag[2] != '0) &&
                ((r_mag[1] == '0) || ((r_sgn[1] == r_sgn[2]) && !ovf_v));
        col_i = (r_mag[0] == '0) ? '0 : LW'(q_u);
        row_i = (r_mag[1] == '0) ? '0 : LW'(q_v);
        land  = u_ok && v_ok && (col_i < lim_cols) && (row_i < lim_rows);
        hit_addr = {row_i[RW-1:0], col_i[CW-1:0]};
        rd_row  = 16'(i_head.row);
        rd_col  = 16'(i_head.col);
        rd_addr = {rd_row[RW-1:0], rd_col[CW-1:0]};
        stored  = ram_rdata;
        upd     = (stored <= 0) || (r_val < stored);
    end

    // Queue pop and memory port control
    always_comb begin
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = rd_addr;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop  = (i_head.op != psmdb_pkg::OP_NULL) || out_free;
                    ram_re = (i_head.op == psmdb_pkg::OP_READ);
                end
            end
            S_CHECK: begin
                ram_re    = land;
                ram_raddr = hit_addr;
            end
            S_RMW: begin
                ram_we    = out_free && upd;
                ram_wdata = r_val;
            end
            S_RDATA: begin
                ram_we = out_free;
            end
            default: begin
            end
        endcase
    end

    // Flag a result register load in this cycle
    always_comb begin
        unique case (r_state)
            S_IDLE:  out_load = o_pop && (i_head.op == psmdb_pkg::OP_NULL);
            S_CHECK: out_load = !land && out_free;
            S_RMW,
            S_RDATA: out_load = out_free;
            default: out_load = 1'b0;
        endcase
    end

    // Sequencer, datapath registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_term      <= '0;
            r_rows      <= psmdb_pkg::SIZE_RESET;
            r_cols      <= psmdb_pkg::SIZE_RESET;
            for (int i = 0; i < 6; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            // Register writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    psmdb_pkg::CFG_C0A:  r_coef[0] <= i_cfg_data;
                    psmdb_pkg::CFG_C0B:  r_coef[1] <= i_cfg_data;
                    psmdb_pkg::CFG_C1A:  r_coef[2] <= i_cfg_data;
                    psmdb_pkg::CFG_C1B:  r_coef[3] <= i_cfg_data;
                    psmdb_pkg::CFG_C2A:  r_coef[4] <= i_cfg_data;
                    psmdb_pkg::CFG_C2B:  r_coef[5] <= i_cfg_data;
                    psmdb_pkg::CFG_ROWS: r_rows <= i_cfg_data[psmdb_pkg::SIZE_W-1:0];
                    psmdb_pkg::CFG_COLS: r_cols <= i_cfg_data[psmdb_pkg::SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end

            // Drop the result once taken, unless a new one replaces it
            if (o_out.valid && o_out.ready && !out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_x     <= i_head.x;
                        r_y     <= i_head.y;
                        r_z     <= i_head.z;
                        r_val   <= i_head.val;
                        r_addr  <= rd_addr;
                        r_term  <= '0;
                        unique case (i_head.op)
                            psmdb_pkg::OP_SPLAT: begin
                                for (int r = 0; r < 3; r++) begin
                                    r_pos[r] <= '0;
                                    r_neg[r] <= '0;
                                end
                                r_state <= S_MUL;
                            end
                            psmdb_pkg::OP_READ: begin
                                r_state <= S_RDATA;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                                r_out       <= '0;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    // Multiply one term, accumulate the previous one by sign
                    for (int r = 0; r < 3; r++) begin
                        if (r_term < 3'(psmdb_pkg::N_TERMS)) begin
                            r_prod[r] <= opa[r] * opb[r];
                        end
                        if (r_term != '0) begin
                            if (r_prod[r][63]) begin
                                r_neg[r] <= r_neg[r] - r_prod[r];
                            end else begin
                                r_pos[r] <= r_pos[r] + r_prod[r];
                            end
                        end
                    end
                    r_term <= r_term + 1'b1;
                    if (r_term == 3'(psmdb_pkg::N_TERMS)) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    // Reduce each row to sign and magnitude
                    for (int r = 0; r < 3; r++) begin
                        if (r_pos[r] >= r_neg[r]) begin
                            r_sgn[r] <= 1'b0;
                            r_mag[r] <= r_pos[r] - r_neg[r];
                        end else begin
                            r_sgn[r] <= 1'b1;
                            r_mag[r] <= r_neg[r] - r_pos[r];
                        end
                    end
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!busy_u && !busy_v) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (land) begin
                        r_addr    <= hit_addr;
                        r_hit_row <= row_i[7:0];
                        r_hit_col <= col_i[7:0];
                        r_state   <= S_RMW;
                    end else if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                S_RMW: begin
                    if (out_free) begin
                        r_out_valid         <= 1'b1;
                        r_out.landed        <= 1'b1;
                        r_out.hit_row       <= r_hit_row;
                        r_out.hit_col       <= r_hit_col;
                        r_out.pixel_value   <= '0;
                        r_state             <= S_IDLE;
                    end
                end
                S_RDATA: begin
                    if (out_free) begin
                        r_out_valid         <= 1'b1;
                        r_out.landed        <= 1'b0;
                        r_out.hit_row       <= '0;
                        r_out.hit_col       <= '0;
                        r_out.pixel_value   <= ram_rdata;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    psmdb_div #(.QW(QW)) u_div_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_mag[0]),
        .i_den   (r_mag[2]),
        .o_busy  (busy_u),
        .o_q     (q_u),
        .o_ovf   (ovf_u)
    );

    psmdb_div #(.QW(QW)) u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_mag[1]),
        .i_den   (r_mag[2]),
        .o_busy  (busy_v),
        .o_q     (q_v),
        .o_ovf   (ovf_v)
    );

    psmdb_ram #(.WIDTH(32), .DEPTH(DEPTH), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.landed      = r_out.landed;
    assign o_out.hit_row     = r_out.hit_row;
    assign o_out.hit_col     = r_out.hit_col;
    assign o_out.pixel_value = r_out.pixel_value;

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we) else $error("store written while idle");
    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVGO) |=> (busy_u && busy_v)) else $error("divider did not start");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_pop) else $error("request popped while busy");
endmodule

// ===== hw/rtl/point_splat_min_depth_buffer.sv =====
// ============================================================================
// point_splat_min_depth_buffer: point projection into a min-value pixel store
// Projects points through a 3x4 camera matrix and keeps the smallest value
// per pixel (zero or below is empty); read requests return and clear a pixel.
// ============================================================================
// After reset the block sweeps the pixel store to zero, one entry a cycle,
// over all 2^(ceil(log2 MAX_ROWS) + ceil(log2 MAX_COLS)) entries (65536 at
// the default size), and takes no request during that pass. A read request
// reads the pixel on leaving idle, then returns and clears it in the read
// data state. A splat runs four multiply terms through three multipliers
// plus one final accumulate, a sign fold, then the bit-serial quotient of
// QW = ceil(log2(max(MAX_ROWS, MAX_COLS) + 1)) bits (9 at the default size)
// for column and row, and if it lands one read-modify-write of the pixel.
// A two-entry queue takes requests until full while the back end works, and
// the result register frees the back end while a result waits.
module point_splat_min_depth_buffer #(
    parameter int MAX_ROWS = psmdb_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = psmdb_pkg::MAX_COLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psmdb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [psmdb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    psmdb_in_if.sink                            i_in,
    psmdb_out_if.source                         o_out
);
    psmdb_pkg::t_req head;
    logic            head_valid;
    logic            pop;
    logic            clearing;

    psmdb_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_clearing   (clearing),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid)
    );

    psmdb_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_clearing   (clearing),
        .o_out        (o_out)
    );
endmodule

// ===== tb/sv/point_splat_min_depth_buffer_tb.sv =====
// ============================================================================
// point_splat_min_depth_buffer_tb: self-checking bench for the splat buffer
// Drives splat and read requests under random backpressure and compares each
// result against an in-bench model of the projection and the min-value store.
// ============================================================================
module point_splat_min_depth_buffer_tb;

    localparam logic KIND_SPLAT = 1'b0;
    localparam logic KIND_READ  = 1'b1;
    localparam int   N_ROWS     = psmdb_pkg::MAX_ROWS_DEF;
    localparam int   N_COLS     = psmdb_pkg::MAX_COLS_DEF;
    localparam int   N_PIX      = N_ROWS * N_COLS;

    typedef struct {
        logic               kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] val;
        logic [7:0]         row;
        logic [7:0]         col;
    } t_point_req;

    typedef struct {
        logic               landed;
        logic [7:0]         hit_row;
        logic [7:0]         hit_col;
        logic signed [31:0] pixel_value;
    } t_pixel_rsp;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [psmdb_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [psmdb_pkg::CFG_DATA_W-1:0] i_cfg_data;

    psmdb_in_if  req_if ();
    psmdb_out_if rsp_if ();

    point_splat_min_depth_buffer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_if.sink),
        .o_out      (rsp_if.source)
    );

    // Bench copy of the block state
    logic [63:0]        cam_coef [6];
    logic [8:0]         img_rows;
    logic [8:0]         img_cols;
    logic signed [31:0] depth_store [N_PIX];

    t_point_req  point_queue [$];
    t_pixel_rsp  due_results [$];
    logic [15:0] hit_pixels [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          failed;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Projection of one matrix row: exact Q32.32 sum as sign and magnitude
    function automatic void project_row(input int r, input logic signed [31:0] x,
                                        input logic signed [31:0] y,
                                        input logic signed [31:0] z,
                                        output bit neg, output logic [65:0] mag);
        logic signed [65:0] c0, c1, c2, c3, sx, sy, sz, acc;
        c0 = $signed(cam_coef[2*r][31:0]);
        c1 = $signed(cam_coef[2*r][63:32]);
        c2 = $signed(cam_coef[2*r+1][31:0]);
        c3 = $signed(cam_coef[2*r+1][63:32]);
        sx = x;
        sy = y;
        sz = z;
        acc = c0 * sx + c1 * sy + c2 * sz + c3 * 66'sd65536;
        neg = acc < 0;
        mag = neg ? -acc : acc;
    endfunction

    // Floor of num/den, accepted only inside [0, lim)
    function automatic bit floor_in_range(input bit nn, input logic [65:0] nm,
                                          input bit dn, input logic [65:0] dm,
                                          input int lim, output int idx);
        logic [65:0] q;
        if (dm == 0) return 0;
        if (nm == 0) begin
            q = 0;
        end else begin
            if (nn != dn) return 0;
            q = nm / dm;
        end
        if (q >= lim) return 0;
        idx = int'(q);
        return 1;
    endfunction

    // Expected result of one request; updates the bench store
    function automatic t_pixel_rsp splat_predict(input t_point_req rq);
        t_pixel_rsp  rs;
        bit          un, vn, wn;
        logic [65:0] um, vm, wm;
        int          rows, cols, col, row, k;
        rs = '{landed: 1'b0, hit_row: 8'd0, hit_col: 8'd0, pixel_value: 32'sd0};
        if (rq.kind == KIND_READ) begin
            k = int'(rq.row) * N_COLS + int'(rq.col);
            rs.pixel_value = depth_store[k];
            depth_store[k] = 32'sd0;
            return rs;
        end
        rows = img_rows > N_ROWS ? N_ROWS : int'(img_rows);
        cols = img_cols > N_COLS ? N_COLS : int'(img_cols);
        project_row(0, rq.x, rq.y, rq.z, un, um);
        project_row(1, rq.x, rq.y, rq.z, vn, vm);
        project_row(2, rq.x, rq.y, rq.z, wn, wm);
        if (!floor_in_range(un, um, wn, wm, cols, col)) return rs;
        if (!floor_in_range(vn, vm, wn, wm, rows, row)) return rs;
        k = row * N_COLS + col;
        if (depth_store[k] <= 0 || rq.val < depth_store[k]) depth_store[k] = rq.val;
        rs.landed = 1'b1;
        rs.hit_row = row[7:0];
        rs.hit_col = col[7:0];
        return rs;
    endfunction

    // Driver: advance to the next request once the current one is taken
    always @(posedge i_clk) begin
        t_point_req rq;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                rq = point_queue.pop_front();
                req_if.valid       <= 1'b1;
                req_if.kind        <= rq.kind;
                req_if.point_x     <= rq.x;
                req_if.point_y     <= rq.y;
                req_if.point_z     <= rq.z;
                req_if.point_value <= rq.val;
                req_if.read_row    <= rq.row;
                req_if.read_col    <= rq.col;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure
    always @(posedge i_clk) begin
        rsp_if.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_point_req rq;
        t_pixel_rsp ex;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            rq = '{kind: req_if.kind, x: req_if.point_x, y: req_if.point_y,
                   z: req_if.point_z, val: req_if.point_value,
                   row: req_if.read_row, col: req_if.read_col};
            due_results.push_back(splat_predict(rq));
        end
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (due_results.size() == 0) begin
                $display("%0t unexpected result landed=%0b row=%0d col=%0d value=%0h",
                         $realtime, rsp_if.landed, rsp_if.hit_row, rsp_if.hit_col,
                         rsp_if.pixel_value);
                failed = 1'b1;
            end else begin
                ex = due_results.pop_front();
                if (rsp_if.landed !== ex.landed) begin
                    $display("%0t landed exp %0b got %0b", $realtime, ex.landed,
                             rsp_if.landed);
                    failed = 1'b1;
                end
                if (rsp_if.hit_row !== ex.hit_row) begin
                    $display("%0t hit_row exp %0d got %0d", $realtime, ex.hit_row,
                             rsp_if.hit_row);
                    failed = 1'b1;
                end
                if (rsp_if.hit_col !== ex.hit_col) begin
                    $display("%0t hit_col exp %0d got %0d", $realtime, ex.hit_col,
                             rsp_if.hit_col);
                    failed = 1'b1;
                end
                if (rsp_if.pixel_value !== ex.pixel_value) begin
                    $display("%0t pixel_value exp %0h got %0h", $realtime,
                             ex.pixel_value, rsp_if.pixel_value);
                    failed = 1'b1;
                end
            end
        end
    end

    // Register write, mirrored into the bench state
    task automatic write_reg(input logic [psmdb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == psmdb_pkg::CFG_ROWS) img_rows = data[8:0];
        else if (idx == psmdb_pkg::CFG_COLS) img_cols = data[8:0];
        else cam_coef[idx] = data;
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Unit matrix: u = x, v = y, w = z
    task automatic load_unit_matrix();
        write_reg(psmdb_pkg::CFG_C0A, {32'h0, psmdb_pkg::Q_ONE});
        write_reg(psmdb_pkg::CFG_C0B, 64'h0);
        write_reg(psmdb_pkg::CFG_C1A, {psmdb_pkg::Q_ONE, 32'h0});
        write_reg(psmdb_pkg::CFG_C1B, 64'h0);
        write_reg(psmdb_pkg::CFG_C2A, 64'h0);
        write_reg(psmdb_pkg::CFG_C2B, {32'h0, psmdb_pkg::Q_ONE});
    endtask

    task automatic add_read(input logic [7:0] r, input logic [7:0] c);
        point_queue.push_back('{kind: KIND_READ, x: $urandom, y: $urandom,
                                z: $urandom, val: $urandom, row: r, col: c});
    endtask

    task automatic add_splat(input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z, input logic signed [31:0] v);
        point_queue.push_back('{kind: KIND_SPLAT, x: x, y: y, z: z, val: v,
                                row: $urandom, col: $urandom});
    endtask

    // Point aimed at a pixel under the unit matrix, either sign of w
    task automatic add_aimed_splat(input int row, input int col);
        longint zm, xm, ym;
        logic signed [31:0] v;
        zm = $urandom_range(1, 32'h40000);
        xm = col * zm + $urandom_range(0, int'(zm - 1));
        ym = row * zm + $urandom_range(0, int'(zm - 1));
        case ($urandom_range(9))
            0:       v = $urandom;
            1:       v = -$signed({1'b0, 31'($urandom_range(0, 5000))});
            default: v = $urandom_range(1, 4000) << 8;
        endcase
        if ($urandom_range(1)) add_splat(-xm, -ym, -zm, v);
        else add_splat(xm, ym, zm, v);
        hit_pixels.push_back({row[7:0], col[7:0]});
    endtask

    task automatic add_random_mix(input int n, input int rows, input int cols);
        int         pick;
        logic [15:0] px;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                add_aimed_splat($urandom_range(0, rows - 1), $urandom_range(0, cols - 1));
            end else if (pick < 85) begin
                if (hit_pixels.size() > 0 && $urandom_range(3) != 0) begin
                    px = hit_pixels[$urandom_range(0, hit_pixels.size() - 1)];
                    add_read(px[15:8], px[7:0]);
                end else begin
                    add_read($urandom, $urandom);
                end
            end else begin
                add_splat($urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic drain();
        while (point_queue.size() > 0 || req_if.valid || due_results.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        failed         = 1'b0;
        send_idle_pct  = 17;
        recv_stall_pct = 50;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        req_if.valid       = 1'b0;
        req_if.kind        = KIND_SPLAT;
        req_if.point_x     = '0;
        req_if.point_y     = '0;
        req_if.point_z     = '0;
        req_if.point_value = '0;
        req_if.read_row    = '0;
        req_if.read_col    = '0;
        rsp_if.ready       = 1'b0;
        for (int i = 0; i < 6; i++) cam_coef[i] = '0;
        img_rows = psmdb_pkg::SIZE_RESET;
        img_cols = psmdb_pkg::SIZE_RESET;
        for (int i = 0; i < N_PIX; i++) depth_store[i] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: full image, unit matrix
        load_unit_matrix();
        write_reg(psmdb_pkg::CFG_ROWS, 64'd256);
        write_reg(psmdb_pkg::CFG_COLS, 64'd256);
        end_writes();
        add_read(8'd0, 8'd0);
        add_read(8'd255, 8'd255);
        add_splat(32'sd0, 32'sd0, psmdb_pkg::Q_ONE, 32'sd5000);      // u zero
        add_splat(32'sd100, 32'sd200, psmdb_pkg::Q_ONE, 32'sd3000);  // smaller wins
        add_splat(32'sd0, 32'sd0, psmdb_pkg::Q_ONE, 32'sd9000);      // larger kept out
        add_read(8'd0, 8'd0);
        add_splat(32'sd0, 32'sd0, psmdb_pkg::Q_ONE, -32'sd7);        // negative stored
        add_splat(32'sd0, 32'sd0, psmdb_pkg::Q_ONE, 32'sd40);        // empty again
        add_read(8'd0, 8'd0);
        add_splat(32'sd0, 32'sd0, 32'sd0, 32'sd1);                   // w zero
        add_splat(-32'sd65536, 32'sd0, psmdb_pkg::Q_ONE, 32'sd1);    // u below zero
        add_splat(32'sd256 <<< 16, 32'sd0, psmdb_pkg::Q_ONE, 32'sd1); // column past edge
        add_splat(32'sd255 <<< 16, 32'sd255 <<< 16, psmdb_pkg::Q_ONE, 32'h7fffffff);
        add_read(8'd255, 8'd255);
        add_splat(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        add_splat(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
        add_splat(-32'sd65536, -32'sd65536, -32'sd65536, 32'sd12);
        add_read(8'd1, 8'd1);
        add_read(8'd0, 8'd1);
        add_random_mix(230, 256, 256);
        drain();

        // Extreme matrix, zero rows: nothing lands
        send_idle_pct  = 50;
        recv_stall_pct = 17;
        write_reg(psmdb_pkg::CFG_C0A, 64'h8000_0000_7fff_ffff);
        write_reg(psmdb_pkg::CFG_C0B, 64'h7fff_ffff_8000_0000);
        write_reg(psmdb_pkg::CFG_C1A, {$urandom, $urandom});
        write_reg(psmdb_pkg::CFG_C1B, 64'hffff_ffff_ffff_ffff);
        write_reg(psmdb_pkg::CFG_C2A, 64'h8000_0000_8000_0000);
        write_reg(psmdb_pkg::CFG_C2B, {$urandom, $urandom});
        write_reg(psmdb_pkg::CFG_ROWS, 64'd0);
        write_reg(psmdb_pkg::CFG_COLS, 64'd300);
        end_writes();
        add_random_mix(60, 1, 1);
        drain();

        // Small image, sizes past the store elsewhere
        load_unit_matrix();
        write_reg(psmdb_pkg::CFG_ROWS, 64'd17);
        write_reg(psmdb_pkg::CFG_COLS, 64'd511);
        end_writes();
        add_random_mix(180, 20, 256);
        drain();

        write_reg(psmdb_pkg::CFG_ROWS, 64'd1);
        write_reg(psmdb_pkg::CFG_COLS, 64'd1);
        end_writes();
        add_random_mix(60, 2, 2);
        drain();

        // Full image, no idling
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(psmdb_pkg::CFG_ROWS, 64'd256);
        write_reg(psmdb_pkg::CFG_COLS, 64'd256);
        end_writes();
        add_random_mix(200, 256, 256);
        drain();

        if (!failed) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
